// ===== src/assert_macros.svh =====
// Assertion helper macros for the RTL of the noise subtractor.
// Needs nothing else; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sgns_pkg.sv =====
// Shared constants and types for the silence-gated noise subtractor.
// Has no dependencies.
`default_nettype none

package sgns_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W   = 16;
    localparam int THR_W      = 38;
    localparam int QNEED_W    = 16;
    localparam int KEEP_W     = 16;
    localparam int QCNT_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 38;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_SQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_NEEDED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_KEEP   = 2'd2;

    // Reset value of the keep factor.
    localparam logic [KEEP_W-1:0] KEEP_RESET = 16'hFFFF;

    // Per-item flags that travel down the pipeline.
    typedef struct packed {
        logic last;
        logic upd;
    } t_flags;

endpackage

`default_nettype wire

// ===== src/silence_gated_noise_subtractor.sv =====
// Silence-gated noise subtractor: top level with the sample and estimate memories.
// Depends on sgns_pkg and assert_macros.svh.
// Usage:
//   Input channel (i_valid / o_stall) carries one signed 16-bit sample per transfer.
//   Output channel (o_valid / i_stall) carries one result per input sample: the
//   sample of the previous block at the same position minus its truncated noise
//   estimate, plus block_end and noise_was_updated flags.
//   Configuration writes arrive on i_cfg_valid / o_cfg_ready (always ready) and
//   must only be issued while the block is idle.
//   Throughput is one sample per cycle while the receiver does not stall. Each
//   result passes from its input transfer through memory read, estimate multiply,
//   estimate update and write-back, then output subtract into the output register.
//   Each entry is read once per sample; held entries are written once per sample,
//   estimate entries only on an update, the estimate write trailing its read by two
//   stages; a read colliding with that write is served from a forwarding register.
//   Reset sets control state and configuration to reset values; no clearing pass is
//   run. Live flags make never-written entries read as zero, so the first block
//   after reset comes out as zeros.
//   When the receiver stalls, results pile up in the pipeline stages; input is
//   still taken until every stage is full, then o_stall rises.
`default_nettype none

module silence_gated_noise_subtractor
    import sgns_pkg::*;
#(
    parameter int BLOCK_SAMPLES   = 128,
    parameter int NOISE_FRAC_BITS = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Sample input channel
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [SAMPLE_W-1:0]   i_sample_in,
    // Result output channel
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic signed [SAMPLE_W-1:0]        o_sample_out,
    output logic                              o_block_end,
    output logic                              o_noise_was_updated,
    // Configuration write channel
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data
);

`include "assert_macros.svh"

    localparam int POS_W  = $clog2(BLOCK_SAMPLES);
    localparam int EST_W  = SAMPLE_W + 1 + NOISE_FRAC_BITS;
    localparam int ESUM_W = 2 * SAMPLE_W - 1 + $clog2(BLOCK_SAMPLES);
    localparam int CMP_W  = (ESUM_W > THR_W) ? ESUM_W : THR_W;
    localparam int PA_W   = EST_W + KEEP_W + 1;
    localparam int PB_W   = SAMPLE_W + KEEP_W + 2;
    localparam int SUM_W  = PA_W + 1;

    localparam logic [POS_W-1:0]         LAST_POS  = POS_W'(BLOCK_SAMPLES - 1);
    localparam logic [KEEP_W:0]          KEEP_ONE  = (KEEP_W + 1)'(1 << KEEP_W);
    localparam logic signed [EST_W:0]    TRUNC_ADD = (EST_W + 1)'((1 << NOISE_FRAC_BITS) - 1);
    localparam logic signed [EST_W:0]    ZERO_ADJ  = '0;

    // Configuration registers.
    logic [THR_W-1:0]   r_thr;
    logic [QNEED_W-1:0] r_quiet_need;
    logic [KEEP_W-1:0]  r_keep;

    // Block tracking state.
    logic [POS_W-1:0]   r_pos;
    logic [ESUM_W-1:0]  r_energy;
    logic [QCNT_W-1:0]  r_quiet_cnt;
    logic               r_upd_pend;
    logic               r_held_live;
    logic               r_est_live;

    // Memories.
    logic signed [SAMPLE_W-1:0] mem_held [BLOCK_SAMPLES];
    logic signed [EST_W-1:0]    mem_est  [BLOCK_SAMPLES];
    logic signed [SAMPLE_W-1:0] r_held_rd;
    logic signed [EST_W-1:0]    r_est_rd;

    // Stage 1: read data present.
    logic                     r_s1_valid;
    logic [POS_W-1:0]         r_s1_pos;
    t_flags                   r_s1_flags;
    logic                     r_s1_held_live;
    logic                     r_s1_est_live;
    logic                     r_s1_fwd;
    logic signed [EST_W-1:0]  r_fwd_est;

    // Stage 2: products present, estimate written back.
    logic                     r_s2_valid;
    logic [POS_W-1:0]         r_s2_pos;
    t_flags                   r_s2_flags;
    logic signed [PA_W-1:0]   r_pa;
    logic signed [PB_W-1:0]   r_pb;
    logic signed [EST_W-1:0]  r_s2_est;
    logic signed [SAMPLE_W-1:0] r_s2_held;

    // Stage 3: updated estimate present.
    logic                     r_s3_valid;
    t_flags                   r_s3_flags;
    logic signed [EST_W-1:0]  r_s3_est;
    logic signed [SAMPLE_W-1:0] r_s3_held;

    // Output register.
    logic                     r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    t_flags                   r_out_flags;

    // Combinational signals.
    logic                     w_en_out;
    logic                     w_en3;
    logic                     w_en2;
    logic                     w_en1;
    logic                     w_acc;
    logic                     w_last;
    logic signed [2*SAMPLE_W-1:0] w_sq32;
    logic [ESUM_W-1:0]        w_esum_next;
    logic                     w_quiet;
    logic signed [EST_W-1:0]  w_est1;
    logic signed [SAMPLE_W-1:0] w_held1;
    logic signed [KEEP_W:0]   w_keep_s;
    logic [KEEP_W:0]          w_mix;
    logic signed [KEEP_W+1:0] w_mix_s;
    logic signed [PA_W-1:0]   w_pa;
    logic signed [PB_W-1:0]   w_pb;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [SUM_W-1:0]  w_shift;
    logic signed [EST_W-1:0]  w_new_est;
    logic                     w_we;
    logic                     w_fwd;
    logic signed [EST_W:0]    w_round;
    logic signed [EST_W:0]    w_adj;
    logic signed [EST_W:0]    w_trunc;
    logic signed [EST_W:0]    w_diff;

    // Pipeline advance: a stage moves when the one after it is empty or moving.
    assign w_en_out = !r_out_valid || !i_stall;
    assign w_en3    = !r_s3_valid || w_en_out;
    assign w_en2    = !r_s2_valid || w_en3;
    assign w_en1    = !r_s1_valid || w_en2;
    assign o_stall  = !w_en1;
    assign w_acc    = i_valid && w_en1;
    assign w_last   = (r_pos == LAST_POS);

    // Configuration writes; the port never pushes back.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr        <= '0;
            r_quiet_need <= '0;
            r_keep       <= KEEP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD_SQ: r_thr        <= i_cfg_data[THR_W-1:0];
                CFG_QUIET_NEEDED: r_quiet_need <= i_cfg_data[QNEED_W-1:0];
                CFG_NOISE_KEEP:   r_keep       <= i_cfg_data[KEEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Block energy: running sum of squares and the quiet decision at block end.
    assign w_sq32      = i_sample_in * i_sample_in;
    assign w_esum_next = r_energy + ESUM_W'($unsigned(w_sq32));
    assign w_quiet     = CMP_W'(w_esum_next) < CMP_W'(r_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_energy    <= '0;
            r_quiet_cnt <= '0;
            r_upd_pend  <= 1'b0;
            r_held_live <= 1'b0;
            r_est_live  <= 1'b0;
        end else if (w_acc) begin
            if (w_last) begin
                r_pos       <= '0;
                r_energy    <= '0;
                r_held_live <= 1'b1;
                if (r_upd_pend) begin
                    r_est_live <= 1'b1;
                end
                if (w_quiet) begin
                    if (r_quiet_cnt > {1'b0, r_quiet_need}) begin
                        r_upd_pend <= 1'b1;
                    end else begin
                        r_quiet_cnt <= r_quiet_cnt + 1'b1;
                        r_upd_pend  <= 1'b0;
                    end
                end else begin
                    r_quiet_cnt <= '0;
                    r_upd_pend  <= 1'b0;
                end
            end else begin
                r_pos    <= r_pos + 1'b1;
                r_energy <= w_esum_next;
            end
        end
    end

    // Held-sample memory: read the old sample and store the new one in the same cycle.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_held_rd      <= mem_held[r_pos];
            mem_held[r_pos] <= i_sample_in;
        end
    end

    // Estimate memory: read at input transfer, write-back from stage 2.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_est_rd <= mem_est[r_pos];
        end
        if (w_we) begin
            mem_est[r_s2_pos] <= w_new_est;
        end
    end

    // Forward the estimate being written when the read hits the same entry.
    assign w_fwd = w_we && (r_s2_pos == r_pos);

    // Stage 1 registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en1) begin
            r_s1_valid <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_pos        <= r_pos;
            r_s1_flags.last <= w_last;
            r_s1_flags.upd  <= r_upd_pend;
            r_s1_held_live  <= r_held_live;
            r_s1_est_live   <= r_est_live;
            r_s1_fwd        <= w_fwd;
            r_fwd_est       <= w_new_est;
        end
    end

    // Stage 1 logic: pick the live values and form the two weighted products.
    assign w_est1   = r_s1_fwd ? r_fwd_est : (r_s1_est_live ? r_est_rd : '0);
    assign w_held1  = r_s1_held_live ? r_held_rd : '0;
    assign w_keep_s = $signed({1'b0, r_keep});
    assign w_mix    = KEEP_ONE - {1'b0, r_keep};
    assign w_mix_s  = $signed({1'b0, w_mix});
    assign w_pa     = w_est1 * w_keep_s;
    assign w_pb     = w_held1 * w_mix_s;

    // Stage 2 registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2 && r_s1_valid) begin
            r_s2_pos   <= r_s1_pos;
            r_s2_flags <= r_s1_flags;
            r_pa       <= w_pa;
            r_pb       <= w_pb;
            r_s2_est   <= w_est1;
            r_s2_held  <= w_held1;
        end
    end

    // Stage 2 logic: floor of the mixed sum over 2^16, written back on update.
    assign w_sum     = SUM_W'(r_pa) + (SUM_W'(r_pb) <<< NOISE_FRAC_BITS);
    assign w_shift   = w_sum >>> KEEP_W;
    assign w_new_est = r_s2_flags.upd ? w_shift[EST_W-1:0] : r_s2_est;
    assign w_we      = w_en3 && r_s2_valid && r_s2_flags.upd;

    // Stage 3 registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_en3) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3 && r_s2_valid) begin
            r_s3_flags <= r_s2_flags;
            r_s3_est   <= w_new_est;
            r_s3_held  <= r_s2_held;
        end
    end

    // Stage 3 logic: cut the estimate toward zero and subtract it.
    assign w_round = r_s3_est[EST_W-1] ? TRUNC_ADD : ZERO_ADJ;
    assign w_adj   = (EST_W + 1)'(r_s3_est) + w_round;
    assign w_trunc = w_adj >>> NOISE_FRAC_BITS;
    assign w_diff  = (EST_W + 1)'(r_s3_held) - w_trunc;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en_out) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out && r_s3_valid) begin
            r_out_sample <= w_diff[SAMPLE_W-1:0];
            r_out_flags  <= r_s3_flags;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_sample_out        = r_out_sample;
    assign o_block_end         = r_out_flags.last;
    assign o_noise_was_updated = r_out_flags.upd;

    // Neighboring items in the pipeline always sit at different positions.
    `ASSERT_IMP(a_pos_distinct, i_clk, i_rst_n, r_s1_valid && r_s2_valid, r_s1_pos != r_s2_pos, "adjacent items share a position")
    // Once the estimate memory is live it stays live.
    `ASSERT_NXT(a_est_live_sticky, i_clk, i_rst_n, r_est_live, r_est_live, "estimate live flag dropped")
    // An update can only be armed by the transfer that closes a block.
    `ASSERT_IMP(a_upd_at_block_end, i_clk, i_rst_n, $rose(r_upd_pend), $past(w_acc && w_last), "update armed outside block end")
    // The energy sum restarts after the last sample of a block.
    `ASSERT_NXT(a_energy_restart, i_clk, i_rst_n, w_acc && w_last, r_energy == '0, "energy sum not cleared at block end")

endmodule

`default_nettype wire
